// File: src/alc_pkg.sv
// Shared constants and segment tables for the ambient light lux calculator.
package alc_pkg;

  localparam int COUNT_W          = 16;
  localparam int SCALE_W          = 19;
  localparam int LUX_W            = 20;
  localparam int COEF_W           = 10;
  localparam int SEGMENTS         = 8;
  localparam int SEG_W            = 3;
  localparam int TABLE_RATIO_BITS = 9;
  localparam int GAIN_SHIFT       = 4;

  typedef logic [COEF_W-1:0] coef_t;
  typedef logic [SEG_W-1:0]  seg_idx_t;

  localparam logic [LUX_W-1:0] LUX_MAX = '1;

  localparam coef_t SEG_LIMIT [SEGMENTS] = '{
    10'h040, 10'h080, 10'h0C0, 10'h100, 10'h138, 10'h19A, 10'h29A, 10'h29A
  };
  localparam coef_t SEG_ICPT [SEGMENTS] = '{
    10'h1F2, 10'h214, 10'h23F, 10'h270, 10'h16F, 10'h0D2, 10'h018, 10'h000
  };
  localparam coef_t SEG_SLOPE [SEGMENTS] = '{
    10'h1BE, 10'h2D1, 10'h37B, 10'h3FE, 10'h1FC, 10'h0FB, 10'h012, 10'h000
  };

  localparam seg_idx_t SEG_FIRST = '0;
  localparam seg_idx_t SEG_LAST  = SEG_W'(SEGMENTS - 1);

endpackage

// File: src/ambient_light_lux_calc_top.sv
// Top level of the two-channel ambient light lux calculator pipeline.
//
//  channel | direction | handshake              | beat
//  in      | sink      | in_valid_i / in_stall_o   | broadband and infrared counts
//  out     | source    | out_valid_o / out_stall_i | lux
//  cfg     | sink      | cfg_valid_i / cfg_ready_o | channel scale
//
// One beat per cycle while no output stall backs up to the input.
// The divider takes one stage per quotient bit, RATIO_FRACTION_BITS + 2 stages.
// Every stage carries a valid bit; a stalled output holds, bubbles upstream still fill.
// Reset clears valid bits and loads the channel scale with gain 16, longest integration.
module ambient_light_lux_calc_top
  import alc_pkg::*;
#(
  parameter int CHANNEL_FRACTION_BITS = 10,
  parameter int RATIO_FRACTION_BITS   = 9,
  parameter int LUX_FRACTION_BITS     = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [COUNT_W-1:0] broadband_count_i,
  input  logic [COUNT_W-1:0] infrared_count_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [LUX_W-1:0]   lux_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [SCALE_W-1:0] cfg_channel_scale_i
);

  localparam int PW  = COUNT_W + SCALE_W;
  localparam int CW  = PW - CHANNEL_FRACTION_BITS;
  localparam int QW  = RATIO_FRACTION_BITS + 2;
  localparam int RW  = CW + QW;
  localparam int SW  = CW + 2;
  localparam int MW  = CW + COEF_W;
  localparam int AW  = MW + 1;
  localparam int NS  = QW + 5;
  localparam int LK  = QW + 2;
  localparam int MU  = QW + 3;
  localparam int OS  = QW + 4;

  localparam logic [SCALE_W-1:0] SCALE_RESET =
    SCALE_W'((64'd1 << CHANNEL_FRACTION_BITS) << GAIN_SHIFT);

  function automatic logic [31:0] limit_at(input int idx);
    logic [31:0] lim;
    lim = 32'(SEG_LIMIT[idx]);
    if (RATIO_FRACTION_BITS >= TABLE_RATIO_BITS) begin
      return lim << (RATIO_FRACTION_BITS - TABLE_RATIO_BITS);
    end
    return lim >> (TABLE_RATIO_BITS - RATIO_FRACTION_BITS);
  endfunction

  logic [SCALE_W-1:0] scale_q;
  logic [NS-1:0]      v;
  logic [NS-1:0]      adv;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      scale_q <= cfg_channel_scale_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // advance chain
  assign adv[NS-1] = ~v[NS-1] | ~out_stall_i;
  for (genvar k = 0; k < NS - 1; k++) begin : g_adv
    assign adv[k] = ~v[k] | adv[k+1];
  end

  assign in_stall_o = ~adv[0];

  // stage 0: scale both counts
  logic          s0_v_q;
  logic [CW-1:0] s0_c0_q, s0_c1_q;
  logic [PW-1:0] prod_bb, prod_ir;

  always_comb begin
    prod_bb = PW'(broadband_count_i) * PW'(scale_q);
    prod_ir = PW'(infrared_count_i) * PW'(scale_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (adv[0]) begin
      s0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && in_valid_i) begin
      s0_c0_q <= prod_bb[PW-1:CHANNEL_FRACTION_BITS];
      s0_c1_q <= prod_ir[PW-1:CHANNEL_FRACTION_BITS];
    end
  end

  assign v[0] = s0_v_q;

  // stage 1: divider setup
  logic          s1_v_q;
  logic [RW-1:0] rem_s  [QW+1];
  logic [CW-1:0] den_s  [QW+1];
  logic [QW-1:0] quo_s  [QW+1];
  logic [SW-1:0] side_s [QW+1];
  logic [RW-1:0] s1_rem_q;
  logic [CW-1:0] s1_den_q;
  logic [SW-1:0] s1_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv[1]) begin
      s1_v_q <= s0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1] && s0_v_q) begin
      s1_rem_q  <= RW'(s0_c1_q) << (RATIO_FRACTION_BITS + 1);
      s1_den_q  <= s0_c0_q;
      s1_side_q <= {s0_c1_q, ({1'b0, s0_c1_q} >= {s0_c0_q, 1'b0}), (s0_c0_q == '0)};
    end
  end

  assign v[1]      = s1_v_q;
  assign rem_s[0]  = s1_rem_q;
  assign den_s[0]  = s1_den_q;
  assign quo_s[0]  = '0;
  assign side_s[0] = s1_side_q;

  // divider stages, most significant quotient bit first
  for (genvar i = 0; i < QW; i++) begin : g_div
    alc_div_stage #(
      .RW  (RW),
      .CW  (CW),
      .QW  (QW),
      .BIT (QW - 1 - i),
      .SW  (SW)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .load_i  (adv[2+i]),
      .valid_i (v[1+i]),
      .rem_i   (rem_s[i]),
      .den_i   (den_s[i]),
      .quo_i   (quo_s[i]),
      .side_i  (side_s[i]),
      .valid_o (v[2+i]),
      .rem_o   (rem_s[i+1]),
      .den_o   (den_s[i+1]),
      .quo_o   (quo_s[i+1]),
      .side_o  (side_s[i+1])
    );
  end

  // segment lookup
  logic          div_zero, div_ovf;
  logic [QW:0]   ratio_rnd;
  logic [QW-1:0] ratio;
  seg_idx_t      seg;
  logic          found;
  logic          lk_v_q;
  coef_t         lk_b_q, lk_m_q;
  logic [CW-1:0] lk_c0_q, lk_c1_q;

  assign div_zero = side_s[QW][0];
  assign div_ovf  = side_s[QW][1];

  always_comb begin
    ratio_rnd = {1'b0, quo_s[QW]} + (QW+1)'(1);
    ratio     = ratio_rnd[QW:1];
    seg       = SEG_LAST;
    found     = 1'b0;
    for (int i = 0; i < SEGMENTS - 1; i++) begin
      if (!found && (32'(ratio) <= limit_at(i))) begin
        seg   = SEG_W'(i);
        found = 1'b1;
      end
    end
    if (div_zero) begin
      seg = SEG_FIRST;
    end else if (div_ovf) begin
      seg = SEG_LAST;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lk_v_q <= 1'b0;
    end else if (adv[LK]) begin
      lk_v_q <= v[LK-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[LK] && v[LK-1]) begin
      lk_b_q  <= SEG_ICPT[seg];
      lk_m_q  <= SEG_SLOPE[seg];
      lk_c0_q <= den_s[QW];
      lk_c1_q <= side_s[QW][SW-1:2];
    end
  end

  assign v[LK] = lk_v_q;

  // products
  logic          mu_v_q;
  logic [MW-1:0] mu_pos_q, mu_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_v_q <= 1'b0;
    end else if (adv[MU]) begin
      mu_v_q <= lk_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[MU] && lk_v_q) begin
      mu_pos_q <= MW'(lk_c0_q) * MW'(lk_b_q);
      mu_neg_q <= MW'(lk_c1_q) * MW'(lk_m_q);
    end
  end

  assign v[MU] = mu_v_q;

  // clamp, round, saturate
  logic [MW-1:0]    diff;
  logic [AW-1:0]    acc, acc_sh;
  logic [LUX_W-1:0] lux_d;
  logic             out_v_q;
  logic [LUX_W-1:0] lux_q;

  always_comb begin
    diff   = (mu_pos_q > mu_neg_q) ? (mu_pos_q - mu_neg_q) : '0;
    acc    = AW'(diff) + (AW'(1) << (LUX_FRACTION_BITS - 1));
    acc_sh = acc >> LUX_FRACTION_BITS;
    lux_d  = (acc_sh > AW'(LUX_MAX)) ? LUX_MAX : acc_sh[LUX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv[OS]) begin
      out_v_q <= mu_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[OS] && mu_v_q) begin
      lux_q <= lux_d;
    end
  end

  assign v[OS]       = out_v_q;
  assign out_valid_o = out_v_q;
  assign lux_o       = lux_q;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v))
    else $error("input stalled while the pipeline has a bubble");

  a_div_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v[QW+1] && !div_zero && !div_ovf) |-> (rem_s[QW] < RW'(den_s[QW])))
    else $error("divider remainder not below divisor");

  a_zero_first_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv[LK] && v[LK-1] && div_zero) |=> (lk_b_q == SEG_ICPT[0] && lk_m_q == SEG_SLOPE[0]))
    else $error("zero broadband count missed the first segment");

  a_ovf_last_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv[LK] && v[LK-1] && !div_zero && div_ovf) |=> (lk_b_q == '0 && lk_m_q == '0))
    else $error("ratio above table did not select zero coefficients");

  a_stalled_output_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !adv[OS])
    else $error("output stage advanced under stall");
`endif

endmodule

// File: src/alc_div_stage.sv
// One restoring-division stage: resolves a single quotient bit per cycle while load_i is high.
module alc_div_stage #(
  parameter int RW  = 36,
  parameter int CW  = 25,
  parameter int QW  = 11,
  parameter int BIT = 0,
  parameter int SW  = 27
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  logic          valid_i,
  input  logic [RW-1:0] rem_i,
  input  logic [CW-1:0] den_i,
  input  logic [QW-1:0] quo_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [RW-1:0] rem_o,
  output logic [CW-1:0] den_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic          valid_q;
  logic [RW-1:0] rem_q, rem_d;
  logic [CW-1:0] den_q;
  logic [QW-1:0] quo_q, quo_d;
  logic [SW-1:0] side_q;
  logic [RW-1:0] dsh;
  logic          take;

  always_comb begin
    dsh   = RW'(den_i) << BIT;
    take  = rem_i >= dsh;
    rem_d = take ? (rem_i - dsh) : rem_i;
    quo_d = quo_i | (QW'(take) << BIT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && valid_i) begin
      rem_q  <= rem_d;
      den_q  <= den_i;
      quo_q  <= quo_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign quo_o   = quo_q;
  assign side_o  = side_q;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the ambient light lux calculator: queued count pairs, checked lux.
module testbench
  import alc_pkg::*;
();

  localparam int CH_FRAC     = 10;
  localparam int RATIO_FRAC  = 9;
  localparam int LUX_FRAC    = 14;
  localparam int SETTLE      = RATIO_FRAC + 12;
  localparam int STUCK_LIMIT = 4000;
  localparam int PHASES      = 8;
  localparam int PHASE_PAIRS = 140;
  localparam logic [SCALE_W-1:0] SCALE_MAX = SCALE_W'(479600);

  typedef struct packed {
    logic [COUNT_W-1:0] broadband;
    logic [COUNT_W-1:0] infrared;
  } count_pair_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [COUNT_W-1:0] broadband_count_i = '0;
  logic [COUNT_W-1:0] infrared_count_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [LUX_W-1:0] lux_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [SCALE_W-1:0] cfg_channel_scale_i = '0;

  count_pair_t pending_pairs[$];
  logic [LUX_W-1:0] lux_expected[$];
  logic [SCALE_W-1:0] scale_setting = SCALE_W'(16384);
  bit no_idle = 1'b0;
  int error_count = 0;
  int pairs_sent = 0;
  int lux_checked = 0;
  int saturated = 0;
  int dark = 0;
  int cfg_writes = 0;
  int stuck_cycles = 0;

  ambient_light_lux_calc_top #(
    .CHANNEL_FRACTION_BITS(CH_FRAC),
    .RATIO_FRACTION_BITS  (RATIO_FRAC),
    .LUX_FRACTION_BITS    (LUX_FRAC)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .broadband_count_i  (broadband_count_i),
    .infrared_count_i   (infrared_count_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .lux_o              (lux_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_channel_scale_i(cfg_channel_scale_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [LUX_W-1:0] predict_lux(logic [COUNT_W-1:0] broadband,
                                                   logic [COUNT_W-1:0] infrared,
                                                   logic [SCALE_W-1:0] scale);
    longint unsigned scaled_bb, scaled_ir, quotient, ratio, bound, pos, neg, acc;
    int seg;
    bit found;
    scaled_bb = (longint'(broadband) * longint'(scale)) >> CH_FRAC;
    scaled_ir = (longint'(infrared) * longint'(scale)) >> CH_FRAC;
    quotient = 0;
    if (scaled_bb != 0) quotient = (scaled_ir << (RATIO_FRAC + 1)) / scaled_bb;
    ratio = (quotient + 1) >> 1;
    seg = SEGMENTS - 1;
    found = 1'b0;
    for (int i = 0; i < SEGMENTS - 1; i++) begin
      bound = longint'(SEG_LIMIT[i]) << (RATIO_FRAC - TABLE_RATIO_BITS);
      if (!found && ratio <= bound) begin
        seg = i;
        found = 1'b1;
      end
    end
    pos = scaled_bb * longint'(SEG_ICPT[seg]);
    neg = scaled_ir * longint'(SEG_SLOPE[seg]);
    acc = (pos > neg) ? pos - neg : 0;
    acc = (acc + (longint'(1) << (LUX_FRAC - 1))) >> LUX_FRAC;
    if (acc > longint'(LUX_MAX)) acc = longint'(LUX_MAX);
    return acc[LUX_W-1:0];
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    error_count++;
  endtask

  function automatic count_pair_t random_pair();
    count_pair_t pair;
    longint unsigned bound;
    logic [COUNT_W-1:0] corners[4] = '{16'h0000, 16'h0001, 16'h8000, 16'hFFFF};
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      pair.broadband = COUNT_W'($urandom_range(65535, 0));
      pair.infrared = COUNT_W'($urandom_range(65535, 0));
    end else if (pick < 55) begin
      pair.broadband = COUNT_W'($urandom_range(65535, 1));
      bound = longint'(SEG_LIMIT[$urandom_range(SEGMENTS - 2, 0)]) + $urandom_range(2, 0);
      bound = (longint'(pair.broadband) * (bound == 0 ? 0 : bound - 1)) >> TABLE_RATIO_BITS;
      bound = bound + $urandom_range(2, 0);
      pair.infrared = (bound > 65535) ? 16'hFFFF : COUNT_W'(bound);
    end else if (pick < 70) begin
      pair.broadband = COUNT_W'($urandom_range(65535, 0));
      pair.infrared = COUNT_W'($urandom_range(65535, pair.broadband));
    end else if (pick < 85) begin
      pair.broadband = COUNT_W'($urandom_range(31, 0));
      pair.infrared = COUNT_W'($urandom_range(31, 0));
    end else begin
      pair.broadband = corners[$urandom_range(3, 0)];
      pair.infrared = corners[$urandom_range(3, 0)];
    end
    return pair;
  endfunction

  task automatic queue_pair(logic [COUNT_W-1:0] broadband, logic [COUNT_W-1:0] infrared);
    count_pair_t pair;
    pair.broadband = broadband;
    pair.infrared = infrared;
    pending_pairs.push_back(pair);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_pairs.size() != 0 || in_valid_i || lux_expected.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_scale(logic [SCALE_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_channel_scale_i <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    scale_setting = value;
    cfg_writes++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_pairs
    count_pair_t pair;
    logic [LUX_W-1:0] lux;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        lux = predict_lux(broadband_count_i, infrared_count_i, scale_setting);
        lux_expected.push_back(lux);
        pairs_sent++;
        if (lux == LUX_MAX) saturated++;
        if (lux == '0) dark++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_pairs.size() != 0 && (no_idle || $urandom_range(99) >= 33)) begin
          pair = pending_pairs.pop_front();
          in_valid_i <= 1'b1;
          broadband_count_i <= pair.broadband;
          infrared_count_i <= pair.infrared;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin : check_lux
    logic [LUX_W-1:0] want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (lux_expected.size() == 0) begin
          report_mismatch("lux beat with nothing outstanding", lux_o, -1);
        end else begin
          want = lux_expected.pop_front();
          if (lux_o !== want) report_mismatch("lux", lux_o, want);
          lux_checked++;
        end
      end
      out_stall_i <= !no_idle && ($urandom_range(99) < 33);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("no handshake for %0d cycles", stuck_cycles);
        $display("TB_ERROR");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    logic [SCALE_W-1:0] phase_scale[PHASES];
    phase_scale = '{
      SCALE_MAX, '0, SCALE_W'(1), SCALE_W'(1024), SCALE_W'(16384),
      SCALE_W'(371370), SCALE_W'(152917), '0
    };
    phase_scale[PHASES-1] = SCALE_W'($urandom_range(479600, 0));
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    queue_pair(16'h0000, 16'h0000);
    queue_pair(16'h0000, 16'hFFFF);
    queue_pair(16'hFFFF, 16'h0000);
    queue_pair(16'hFFFF, 16'hFFFF);
    queue_pair(16'h0001, 16'h0000);
    queue_pair(16'd100, 16'd200);
    // walk each segment limit and the step just past it
    for (int i = 0; i < SEGMENTS - 1; i++) begin
      queue_pair(16'd512, COUNT_W'(SEG_LIMIT[i]));
      queue_pair(16'd512, COUNT_W'(SEG_LIMIT[i]) + 16'd1);
    end
    queue_pair(16'd1024, 16'd129);
    queue_pair(16'd1024, 16'd257);
    wait_drained();

    write_scale(SCALE_MAX);
    @(negedge clk_i);
    queue_pair(16'hFFFF, 16'h0000);
    queue_pair(16'hFFFF, 16'hFFFF);
    queue_pair(16'hFFFF, 16'h8000);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      write_scale(phase_scale[p]);
      @(negedge clk_i);
      no_idle = (p == 3);
      for (int n = 0; n < PHASE_PAIRS / 2; n++) pending_pairs.push_back(random_pair());
      // hold off until the pipeline has emptied
      wait_drained();
      for (int n = 0; n < PHASE_PAIRS / 2; n++) pending_pairs.push_back(random_pair());
      wait_drained();
    end

    $display("sent %0d count pairs over %0d scale writes; checked %0d lux beats",
             pairs_sent, cfg_writes, lux_checked);
    $display("saturated results %0d, zero-lux results %0d", saturated, dark);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
